[design/cdtdn_pkg.sv]
package cdtdn_pkg;

    typedef logic [13:0]        year_t;
    typedef logic [6:0]         md_t;
    typedef logic signed [22:0] day_num_t;

    localparam year_t YEAR_MIN = 14'd1900;
    localparam year_t YEAR_MAX = 14'd9999;

    // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for any 14-bit x
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;

    // floor(x / 7) = (x * DIV7_MUL) >> DIV7_SHIFT for x below 2**24
    localparam int unsigned DIV7_MUL   = 9586981;
    localparam int unsigned DIV7_SHIFT = 26;

    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned YEARS_PER_ERA = 400;
    localparam int unsigned DAYS_PER_ERA  = 146097;
    localparam int unsigned EPOCH_SHIFT   = 719468;
    localparam int unsigned WEEK_MAX      = 524287;

    localparam day_num_t TERM_START_RESET = 23'sd20339;

    // days from March 1 to the first of the month, year starting in March
    function automatic logic [8:0] month_base(input md_t m);
        logic [8:0] b;
        begin
            unique case (m)
                7'd3:    b = 9'd0;
                7'd4:    b = 9'd31;
                7'd5:    b = 9'd61;
                7'd6:    b = 9'd92;
                7'd7:    b = 9'd122;
                7'd8:    b = 9'd153;
                7'd9:    b = 9'd184;
                7'd10:   b = 9'd214;
                7'd11:   b = 9'd245;
                7'd12:   b = 9'd275;
                7'd1:    b = 9'd306;
                7'd2:    b = 9'd337;
                default: b = 9'd0;
            endcase
            return b;
        end
    endfunction

    function automatic logic [4:0] month_len(input md_t m, input logic leap);
        logic [4:0] n;
        begin
            unique case (m) inside
                7'd2:                        n = leap ? 5'd29 : 5'd28;
                7'd4, 7'd6, 7'd9, 7'd11:     n = 5'd30;
                default:                     n = 5'd31;
            endcase
            return n;
        end
    endfunction

endpackage

[design/civil_date_to_day_number.sv]
// Gregorian date check and conversion to days since 1970-01-01.
// A request accepted at a clock edge passes through an 8-stage register pipeline
// and shows its result on the result ports with done high.
// Throughput: one request per cycle; busy is never raised and the receiver cannot stall.
// Reset: rst_n clears the pipeline valid bits and done; term start returns to 2025-09-08.
module civil_date_to_day_number (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  cdtdn_pkg::year_t          year,
    input  cdtdn_pkg::md_t            month,
    input  cdtdn_pkg::md_t            day,
    input  logic                      cfg_we,
    input  cdtdn_pkg::day_num_t       cfg_wdata,
    output logic                      done,
    output logic                      valid_res,
    output cdtdn_pkg::day_num_t       day_number,
    output logic [2:0]                weekday,
    output logic [18:0]               teaching_week
);
    import cdtdn_pkg::*;

    day_num_t   term_start_reg;

    // stage 1: input register
    logic       s1_vld_reg;
    year_t      s1_year_reg;
    md_t        s1_month_reg;
    md_t        s1_day_reg;

    // stage 2: quotients by 100, range checks, month offset
    logic       s2_vld_reg;
    year_t      s2_year_reg;
    year_t      s2_ya_reg;
    logic [7:0] s2_qy_reg;
    logic [7:0] s2_qya_reg;
    logic       s2_range_ok_reg;
    md_t        s2_month_reg;
    md_t        s2_day_reg;
    logic [8:0] s2_base_reg;

    year_t      ya_next;
    logic [26:0] prod_y;
    logic [26:0] prod_ya;

    // stage 3: leap rule, day check, era split
    logic       s3_vld_reg;
    logic       s3_ok_reg;
    logic [5:0] s3_era_reg;
    logic [8:0] s3_yoe_reg;
    logic [1:0] s3_yoec_reg;
    logic [8:0] s3_doy_reg;

    logic       cent_zero;
    logic       leap;
    logic       ok_next;
    logic [5:0] era_next;
    logic [13:0] yoe_full;

    // stage 4: day of era and era days
    logic       s4_vld_reg;
    logic       s4_ok_reg;
    logic [17:0] s4_doe_reg;
    logic [23:0] s4_era_days_reg;

    // stage 5: day count
    logic       s5_vld_reg;
    logic       s5_ok_reg;
    logic [23:0] s5_u_reg;
    day_num_t   s5_days_reg;

    logic [23:0] u_next;

    // stage 6: operands of the two divisions by 7
    logic       s6_vld_reg;
    logic       s6_ok_reg;
    day_num_t   s6_days_reg;
    logic [23:0] s6_wdx_reg;
    logic signed [23:0] s6_diff_reg;

    logic signed [23:0] diff_next;

    // stage 7: quotients by 7
    logic       s7_vld_reg;
    logic       s7_ok_reg;
    day_num_t   s7_days_reg;
    logic [23:0] s7_wdx_reg;
    logic       s7_neg_reg;
    logic [21:0] s7_qwd_reg;
    logic [21:0] s7_qdiff_reg;

    logic [47:0] prod_wd;
    logic [47:0] prod_diff;

    // output register
    logic       done_reg;
    logic       valid_res_reg;
    day_num_t   day_number_reg;
    logic [2:0] weekday_reg;
    logic [18:0] teaching_week_reg;

    logic [23:0] wd_rem;
    logic [21:0] week_sum;
    logic [18:0] week_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_start_reg <= TERM_START_RESET;
        end
        else if (cfg_we)
        begin
            term_start_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            done_reg   <= s7_vld_reg;
        end
    end

    // ---- stage 1 ----
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_year_reg  <= year;
            s1_month_reg <= month;
            s1_day_reg   <= day;
        end
    end

    // ---- stage 2 ----
    always_comb
    begin
        // January and February count with the previous year
        ya_next = s1_year_reg - ((s1_month_reg <= 7'd2) ? 14'd1 : 14'd0);
        prod_y  = {13'd0, s1_year_reg} * 27'(DIV100_MUL);
        prod_ya = {13'd0, ya_next} * 27'(DIV100_MUL);
    end

    always_ff @(posedge clk)
    begin
        s2_year_reg     <= s1_year_reg;
        s2_ya_reg       <= ya_next;
        s2_qy_reg       <= prod_y[DIV100_SHIFT +: 8];
        s2_qya_reg      <= prod_ya[DIV100_SHIFT +: 8];
        s2_range_ok_reg <= (s1_year_reg >= YEAR_MIN) && (s1_year_reg <= YEAR_MAX) &&
                           (s1_month_reg >= 7'd1) && (s1_month_reg <= 7'd12) &&
                           (s1_day_reg >= 7'd1);
        s2_month_reg    <= s1_month_reg;
        s2_day_reg      <= s1_day_reg;
        s2_base_reg     <= month_base(s1_month_reg);
    end

    // ---- stage 3 ----
    always_comb
    begin
        cent_zero = (s2_year_reg == {6'd0, s2_qy_reg} * 14'd100);
        leap      = ((s2_year_reg[1:0] == 2'd0) && !cent_zero) ||
                    (cent_zero && (s2_qy_reg[1:0] == 2'd0));
        ok_next   = s2_range_ok_reg &&
                    (s2_day_reg <= {2'd0, month_len(s2_month_reg, leap)});
        era_next  = s2_qya_reg[7:2];
        yoe_full  = s2_ya_reg - 14'({8'd0, era_next} * 14'(YEARS_PER_ERA));
    end

    always_ff @(posedge clk)
    begin
        s3_ok_reg   <= ok_next;
        s3_era_reg  <= era_next;
        s3_yoe_reg  <= yoe_full[8:0];
        // yoe / 100 is the year quotient by 100 taken mod 4
        s3_yoec_reg <= s2_qya_reg[1:0];
        s3_doy_reg  <= s2_base_reg + {2'd0, s2_day_reg} - 9'd1;
    end

    // ---- stage 4 ----
    always_ff @(posedge clk)
    begin
        s4_ok_reg       <= s3_ok_reg;
        s4_doe_reg      <= 18'(s3_yoe_reg) * 18'(DAYS_PER_YEAR) +
                           18'(s3_yoe_reg[8:2]) - 18'(s3_yoec_reg) + 18'(s3_doy_reg);
        s4_era_days_reg <= 24'(s3_era_reg) * 24'(DAYS_PER_ERA);
    end

    // ---- stage 5 ----
    assign u_next = s4_era_days_reg + 24'(s4_doe_reg);

    always_ff @(posedge clk)
    begin
        s5_ok_reg   <= s4_ok_reg;
        s5_u_reg    <= u_next;
        s5_days_reg <= day_num_t'(u_next - 24'(EPOCH_SHIFT));
    end

    // ---- stage 6 ----
    assign diff_next = 24'(s5_days_reg) - 24'(term_start_reg);

    always_ff @(posedge clk)
    begin
        s6_ok_reg   <= s5_ok_reg;
        s6_days_reg <= s5_days_reg;
        // epoch offset is 1 mod 7 and 1970-01-01 is a Thursday
        s6_wdx_reg  <= s5_u_reg + 24'd2;
        s6_diff_reg <= diff_next;
    end

    // ---- stage 7 ----
    always_comb
    begin
        prod_wd   = {24'd0, s6_wdx_reg} * 48'(DIV7_MUL);
        prod_diff = {24'd0, s6_diff_reg} * 48'(DIV7_MUL);
    end

    always_ff @(posedge clk)
    begin
        s7_ok_reg    <= s6_ok_reg;
        s7_days_reg  <= s6_days_reg;
        s7_wdx_reg   <= s6_wdx_reg;
        s7_neg_reg   <= s6_diff_reg[23];
        s7_qwd_reg   <= prod_wd[DIV7_SHIFT +: 22];
        s7_qdiff_reg <= prod_diff[DIV7_SHIFT +: 22];
    end

    // ---- output ----
    always_comb
    begin
        wd_rem   = s7_wdx_reg - 24'({2'd0, s7_qwd_reg} * 24'd7);
        week_sum = s7_qdiff_reg + 22'd1;
        if (s7_neg_reg)
        begin
            week_next = 19'd0;
        end
        else if (week_sum > 22'(WEEK_MAX))
        begin
            week_next = 19'(WEEK_MAX);
        end
        else
        begin
            week_next = week_sum[18:0];
        end
    end

    always_ff @(posedge clk)
    begin
        valid_res_reg     <= s7_ok_reg;
        day_number_reg    <= s7_ok_reg ? s7_days_reg : '0;
        weekday_reg       <= s7_ok_reg ? wd_rem[2:0] : 3'd0;
        teaching_week_reg <= s7_ok_reg ? week_next : 19'd0;
    end

    assign done          = done_reg;
    assign valid_res     = valid_res_reg;
    assign day_number    = day_number_reg;
    assign weekday       = weekday_reg;
    assign teaching_week = teaching_week_reg;

endmodule

[test/tb_civil_date_to_day_number.sv]
module tb_civil_date_to_day_number;
    import cdtdn_pkg::*;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int RAND_PER_PHASE  = 130;
    localparam int DRAIN_CYCLES    = 12;
    localparam int NUM_TERMS       = 7;

    typedef struct {
        year_t y;
        md_t   m;
        md_t   d;
    } date_req_t;

    typedef struct {
        logic        valid;
        day_num_t    days;
        logic [2:0]  wd;
        logic [18:0] week;
    } day_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    year_t       year = '0;
    md_t         month = '0;
    md_t         day = '0;
    logic        cfg_we = 1'b0;
    day_num_t    cfg_wdata = '0;
    logic        done;
    logic        valid_res;
    day_num_t    day_number;
    logic [2:0]  weekday;
    logic [18:0] teaching_week;

    date_req_t   pend_q[$];
    day_result_t exp_q[$];
    day_num_t    term_cfg;
    day_result_t mon_exp;
    date_req_t   drv_req;
    int          acc_cnt;
    int          iss_cnt = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          err_cnt = 0;
    int          cyc = 0;

    civil_date_to_day_number u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .year         (year),
        .month        (month),
        .day          (day),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .valid_res    (valid_res),
        .day_number   (day_number),
        .weekday      (weekday),
        .teaching_week(teaching_week)
    );

    always #5 clk = ~clk;

    function automatic int days_in_month(input int y, input int m);
        bit leap;
        begin
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            if (m == 2)
                return leap ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        end
    endfunction

    // days-from-civil on a March-based year, then weekday and week index
    function automatic day_result_t convert_date(input year_t y, input md_t m, input md_t d,
                                                 input day_num_t term);
        day_result_t r;
        longint ya, era, yoe, mp, doy, doe, days, wd, diff, week;
        begin
            r = '{valid: 1'b0, days: '0, wd: '0, week: '0};
            if (y < YEAR_MIN || y > YEAR_MAX || m < 1 || m > 12 || d < 1 ||
                int'(d) > days_in_month(int'(y), int'(m)))
                return r;
            ya   = longint'(y) - ((m <= 2) ? 1 : 0);
            era  = ya / 400;
            yoe  = ya - era * 400;
            mp   = (m > 2) ? longint'(m) - 3 : longint'(m) + 9;
            doy  = (153 * mp + 2) / 5 + longint'(d) - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * 146097 + doe - 719468;
            wd   = (days + 3) % 7;
            if (wd < 0)
                wd += 7;
            diff = days - longint'(term);
            week = (diff < 0) ? 0 : diff / 7 + 1;
            if (week > WEEK_MAX)
                week = WEEK_MAX;
            r.valid = 1'b1;
            r.days  = day_num_t'(days);
            r.wd    = wd[2:0];
            r.week  = week[18:0];
            return r;
        end
    endfunction

    // mostly well-formed dates, some one field off the edge, some raw noise
    function automatic date_req_t random_date();
        date_req_t r;
        int kind;
        begin
            kind = int'($urandom_range(0, 99));
            case ($urandom_range(0, 9)) inside
                0:       r.y = 14'd1900;
                1:       r.y = 14'd9999;
                2, 3, 4: r.y = year_t'($urandom_range(1960, 2040));
                default: r.y = year_t'($urandom_range(1900, 9999));
            endcase
            r.m = md_t'($urandom_range(1, 12));
            r.d = md_t'($urandom_range(1, days_in_month(int'(r.y), int'(r.m))));
            if (kind >= 85) begin
                r.y = year_t'($urandom_range(0, 16383));
                r.m = md_t'($urandom_range(0, 127));
                r.d = md_t'($urandom_range(0, 127));
            end else if (kind >= 70) begin
                case ($urandom_range(0, 5))
                    0:       r.d = 7'd0;
                    1:       r.d = md_t'(days_in_month(int'(r.y), int'(r.m)) + 1);
                    2:       r.m = 7'd0;
                    3:       r.m = 7'd13;
                    4:       r.y = 14'd1899;
                    default: r.y = 14'd10000;
                endcase
            end
            return r;
        end
    endfunction

    task automatic push_date(input int y, input int m, input int d);
        date_req_t r;
        begin
            r.y = year_t'(y);
            r.m = md_t'(m);
            r.d = md_t'(d);
            pend_q.insert(pend_q.size(), r);
        end
    endtask

    task automatic wait_idle();
        begin
            @(negedge clk);
            while (!(pend_q.size() == 0 && acc_cnt == iss_cnt && exp_q.size() == 0))
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end
    endtask

    // request driver: bursts with random gaps, holds a request until taken
    always @(negedge clk) begin
        int mode;
        if (rst_n && !(start && acc_cnt != iss_cnt)) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left = gap_left - 1;
            end else if (pend_q.size() != 0) begin
                drv_req = pend_q.pop_front();
                year  <= drv_req.y;
                month <= drv_req.m;
                day   <= drv_req.d;
                start <= 1'b1;
                iss_cnt = iss_cnt + 1;
                if (burst_left > 1) begin
                    burst_left = burst_left - 1;
                end else begin
                    mode = int'($urandom_range(0, 3));
                    if (mode == 0) begin
                        burst_left = int'($urandom_range(50, 120));
                        gap_left   = 0;
                    end else begin
                        burst_left = int'($urandom_range(1, 12));
                        gap_left   = int'($urandom_range(1, (mode == 1) ? 20 : 4));
                    end
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor and expectation capture
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            term_cfg <= TERM_START_RESET;
            acc_cnt  <= 0;
        end else begin
            if (done) begin
                if (exp_q.size() == 0) begin
                    $error("result with no request pending");
                    err_cnt++;
                end else begin
                    mon_exp = exp_q.pop_front();
                    if (valid_res !== mon_exp.valid) begin
                        $error("valid_res mismatch: expected %0d, got %0d",
                               mon_exp.valid, valid_res);
                        err_cnt++;
                    end
                    if (day_number !== mon_exp.days) begin
                        $error("day_number mismatch: expected %0d, got %0d",
                               mon_exp.days, day_number);
                        err_cnt++;
                    end
                    if (weekday !== mon_exp.wd) begin
                        $error("weekday mismatch: expected %0d, got %0d",
                               mon_exp.wd, weekday);
                        err_cnt++;
                    end
                    if (teaching_week !== mon_exp.week) begin
                        $error("teaching_week mismatch: expected %0d, got %0d",
                               mon_exp.week, teaching_week);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy) begin
                exp_q.insert(exp_q.size(), convert_date(year, month, day, term_cfg));
                acc_cnt <= acc_cnt + 1;
            end
            if (cfg_we)
                term_cfg <= cfg_wdata;
        end
    end

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int terms[NUM_TERMS];
        int i;
        // third entry, far below the legal range, drives the week into saturation
        terms = '{-25567, 2932896, -4194304, 0, 0, 0, 20339};
        terms[4] = int'($urandom_range(0, 2958463)) - 25567;
        terms[5] = int'($urandom_range(0, 2958463)) - 25567;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: range ends, epoch, term start edges, leap rule, bad fields
        push_date(1900, 1, 1);
        push_date(9999, 12, 31);
        push_date(1970, 1, 1);
        push_date(1969, 12, 31);
        push_date(2025, 9, 7);
        push_date(2025, 9, 8);
        push_date(2025, 9, 14);
        push_date(2025, 9, 15);
        push_date(2000, 2, 29);
        push_date(1900, 2, 29);
        push_date(2100, 2, 29);
        push_date(2024, 2, 29);
        push_date(2023, 2, 29);
        push_date(2023, 2, 28);
        push_date(1899, 12, 31);
        push_date(10000, 1, 1);
        push_date(16383, 127, 127);
        push_date(0, 0, 0);
        push_date(2025, 13, 1);
        push_date(2025, 0, 10);
        push_date(2025, 4, 31);
        push_date(2025, 4, 30);
        push_date(2025, 1, 0);
        push_date(2025, 12, 32);
        repeat (RAND_PER_PHASE) pend_q.insert(pend_q.size(), random_date());
        wait_idle();

        for (i = 0; i < NUM_TERMS; i++) begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= day_num_t'(terms[i]);
            @(negedge clk);
            cfg_we    <= 1'b0;
            @(posedge clk);
            repeat (RAND_PER_PHASE) pend_q.insert(pend_q.size(), random_date());
            wait_idle();
        end

        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
